// File: src/tedsc_pkg.sv
// ============================================================================
// tedsc_pkg
// Shared types, constants and helpers for the text entity decoder with
// whitespace collapsing: item structs, entity tables, controller encodings.
// ============================================================================
package tedsc_pkg;

    localparam int CHAR_W              = 8;
    localparam int LEN_W               = 10;
    localparam int LOOKAHEAD_DEPTH_DEF = 5;
    localparam int NUM_ENT             = 4;
    localparam int ENT_MAX_LEN         = 6;

    localparam logic [LEN_W-1:0] MAX_OUTPUT_CHARS_RST = 10'd767;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    // Entity spellings, lower case, padded with NUL
    localparam logic [CHAR_W-1:0] ENT_TEXT [NUM_ENT][ENT_MAX_LEN] = '{
        '{"&", "l", "t", ";", CHAR_NUL, CHAR_NUL},
        '{"&", "g", "t", ";", CHAR_NUL, CHAR_NUL},
        '{"&", "a", "m", "p", ";",      CHAR_NUL},
        '{"&", "n", "b", "s", "p",      ";"}
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd4, 3'd4, 3'd5, 3'd6};
    localparam logic [CHAR_W-1:0] ENT_VAL [NUM_ENT] = '{"<", ">", "&", CHAR_SPACE};

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              end_of_run;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              is_end;
        logic [LEN_W-1:0]  run_length;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAKE,
        ST_PUT,
        ST_FLUSH,
        ST_FRESH,
        ST_END_EMIT,
        ST_FINISH
    } ctl_state_t;

    // Character source for a put step
    typedef enum logic [1:0] {
        SRC_BYTE,
        SRC_ENT,
        SRC_HELD
    } put_src_t;

    // What follows a replay of held bytes
    typedef enum logic [1:0] {
        FL_TAKE_CHK,
        FL_TAKE_NOCHK,
        FL_END
    } flush_mode_t;

    typedef struct packed {
        logic     load;
        logic     hold_amp;
        logic     append;
        logic     latch_ent;
        logic     put_en;
        put_src_t put_src;
        logic     flush_clear;
        logic     emit_end;
        logic     finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic go;
        logic full;
        logic end_flag;
        logic count_zero;
        logic is_amp;
        logic match;
        logic match_full;
        logic at_depth;
        logic flush_done;
        logic put_done;
    } ctl_status_t;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_DIFF : c;
    endfunction

    function automatic logic is_white(input logic [CHAR_W-1:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
    endfunction

    // Entity character at a position, NUL past the table
    function automatic logic [CHAR_W-1:0] ent_char(input int k, input int pos);
        return (pos < ENT_MAX_LEN) ? ENT_TEXT[k][pos] : CHAR_NUL;
    endfunction

endpackage

// File: src/tedsc_ctrl.sv
// ============================================================================
// tedsc_ctrl
// Sequencer for the decoder: walks one input byte through entity matching,
// replay of held bytes, character output and end-of-run reporting.
// ============================================================================
module tedsc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tedsc_pkg::ctl_status_t status,
    output tedsc_pkg::ctl_cmd_t    cmd
);
    import tedsc_pkg::*;

    ctl_state_t  state_reg, state_next;
    flush_mode_t mode_reg,  mode_next;
    put_src_t    src_reg,   src_next;
    logic        to_end;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= FL_TAKE_CHK;
            src_reg   <= SRC_BYTE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            src_reg   <= src_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        src_next   = src_reg;
        to_end     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_TAKE;
            end
            ST_TAKE: begin
                if (status.go) begin
                    if (status.full) begin
                        to_end = 1'b1;
                    end else if (status.count_zero) begin
                        if (status.is_amp) begin
                            to_end = 1'b1;
                        end else begin
                            state_next = ST_PUT;
                            src_next   = SRC_BYTE;
                        end
                    end else if (status.match && status.match_full) begin
                        state_next = ST_PUT;
                        src_next   = SRC_ENT;
                    end else if (status.match && !status.at_depth) begin
                        to_end = 1'b1;
                    end else begin
                        state_next = ST_FLUSH;
                        mode_next  = status.match ? FL_TAKE_NOCHK : FL_TAKE_CHK;
                    end
                end
            end
            ST_PUT: begin
                if (status.go && status.put_done) to_end = 1'b1;
            end
            ST_FLUSH: begin
                if (status.go && status.flush_done) begin
                    state_next = (mode_reg == FL_END) ? ST_END_EMIT : ST_FRESH;
                end
            end
            ST_FRESH: begin
                if (status.go) begin
                    if ((mode_reg == FL_TAKE_CHK && status.full) || status.is_amp) begin
                        to_end = 1'b1;
                    end else begin
                        state_next = ST_PUT;
                        src_next   = SRC_BYTE;
                    end
                end
            end
            ST_END_EMIT: begin
                if (status.go) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.go) state_next = s_valid ? ST_TAKE : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // Item work done: replay held bytes and report, or wrap up
        if (to_end) begin
            if (status.end_flag) begin
                state_next = ST_FLUSH;
                mode_next  = FL_END;
            end else begin
                state_next = ST_FINISH;
            end
        end
    end

    // Commands
    always_comb begin
        cmd         = '0;
        cmd.put_src = src_reg;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_TAKE: begin
                if (!status.full) begin
                    if (status.count_zero) begin
                        cmd.hold_amp = status.is_amp;
                    end else if (status.match && status.match_full) begin
                        cmd.latch_ent = 1'b1;
                    end else if (status.match && !status.at_depth) begin
                        cmd.append = 1'b1;
                    end
                end
            end
            ST_PUT: begin
                cmd.put_en = 1'b1;
            end
            ST_FLUSH: begin
                if (status.flush_done) begin
                    cmd.flush_clear = 1'b1;
                end else begin
                    cmd.put_en  = 1'b1;
                    cmd.put_src = SRC_HELD;
                end
            end
            ST_FRESH: begin
                if (!(mode_reg == FL_TAKE_CHK && status.full)) cmd.hold_amp = status.is_amp;
            end
            ST_END_EMIT: begin
                cmd.emit_end = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                s_ready    = status.go;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.load = s_valid && s_ready;
    end

endmodule

// File: src/tedsc_dp.sv
// ============================================================================
// tedsc_dp
// Datapath: entity lookahead buffer and matcher, whitespace collapse and
// capacity counter, result staging and output register, config register.
// ============================================================================
module tedsc_dp #(
    parameter int LOOKAHEAD_DEPTH = tedsc_pkg::LOOKAHEAD_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tedsc_pkg::in_item_t               s_data,
    input  tedsc_pkg::ctl_cmd_t               cmd,
    output tedsc_pkg::ctl_status_t            status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tedsc_pkg::out_item_t              m_data,
    input  logic                              cfg_wr_en,
    input  logic [tedsc_pkg::LEN_W-1:0]       cfg_wr_data
);
    import tedsc_pkg::*;

    localparam int CNT_W = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int IDX_W = $clog2(LOOKAHEAD_DEPTH);

    logic [CHAR_W-1:0] byte_reg, byte_next;
    logic              end_reg, end_next;
    logic [CHAR_W-1:0] buf_reg [LOOKAHEAD_DEPTH];
    logic [CHAR_W-1:0] buf_next [LOOKAHEAD_DEPTH];
    logic [CHAR_W-1:0] ent_char_reg, ent_char_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              sp_reg, sp_next;
    logic [LEN_W-1:0]  emitted_reg, emitted_next;
    logic [LEN_W-1:0]  max_reg, max_next;
    logic              hold_valid_reg, hold_valid_next;
    out_item_t         hold_data_reg, hold_data_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              go;
    logic              full;
    logic              hit, hit_full;
    logic [CHAR_W-1:0] hit_val;
    logic [CHAR_W-1:0] put_c;
    logic              put_white, need_sp, put_done, put_emits;
    logic [CHAR_W-1:0] put_out;
    logic              emit_new;
    out_item_t         new_item;

    assign go   = !hold_valid_reg || !m_valid_reg || m_ready;
    assign full = emitted_reg >= max_reg;

    // Entity matcher: held prefix plus this byte against each spelling
    always_comb begin
        logic [CNT_W:0] cnt_p1;
        logic           ok;
        cnt_p1   = {1'b0, count_reg} + (CNT_W+1)'(1);
        hit      = 1'b0;
        hit_full = 1'b0;
        hit_val  = CHAR_NUL;
        for (int k = 0; k < NUM_ENT; k++) begin
            ok = cnt_p1 <= (CNT_W+1)'(ENT_LEN[k]);
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
                if (CNT_W'(i) < count_reg && fold_case(buf_reg[i]) != ent_char(k, i)) begin
                    ok = 1'b0;
                end
            end
            if (count_reg >= CNT_W'(ENT_MAX_LEN)) begin
                ok = 1'b0;
            end
            for (int j = 0; j < ENT_MAX_LEN; j++) begin
                if (count_reg == CNT_W'(j) && fold_case(byte_reg) != ent_char(k, j)) begin
                    ok = 1'b0;
                end
            end
            if (ok && !hit) begin
                hit      = 1'b1;
                hit_full = cnt_p1 == (CNT_W+1)'(ENT_LEN[k]);
                hit_val  = ENT_VAL[k];
            end
        end
    end

    // One put step: collapsed space first, then the character
    always_comb begin
        case (cmd.put_src)
            SRC_BYTE: put_c = byte_reg;
            SRC_ENT:  put_c = ent_char_reg;
            SRC_HELD: put_c = buf_reg[idx_reg[IDX_W-1:0]];
            default:  put_c = byte_reg;
        endcase
        put_white = is_white(put_c);
        need_sp   = sp_reg && emitted_reg != '0
                    && ({1'b0, emitted_reg} + (LEN_W+1)'(1)) < {1'b0, max_reg};
        put_done  = full || put_white || !need_sp;
        put_emits = !full && !put_white;
        put_out   = need_sp ? CHAR_SPACE : put_c;
    end

    assign status.go         = go;
    assign status.full       = full;
    assign status.end_flag   = end_reg;
    assign status.count_zero = count_reg == '0;
    assign status.is_amp     = byte_reg == CHAR_AMP;
    assign status.match      = hit;
    assign status.match_full = hit_full;
    assign status.at_depth   = count_reg == CNT_W'(LOOKAHEAD_DEPTH);
    assign status.flush_done = idx_reg == count_reg;
    assign status.put_done   = put_done;

    // Next-state logic for the datapath registers
    always_comb begin
        byte_next       = byte_reg;
        end_next        = end_reg;
        buf_next        = buf_reg;
        ent_char_next   = ent_char_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        sp_next         = sp_reg;
        emitted_next    = emitted_reg;
        max_next        = cfg_wr_en ? cfg_wr_data : max_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        emit_new = go && ((cmd.put_en && put_emits) || cmd.emit_end);
        new_item = '0;
        if (cmd.emit_end) begin
            new_item.is_end     = 1'b1;
            new_item.run_length = emitted_reg;
        end else begin
            new_item.out_char = put_out;
        end

        if (cmd.load) begin
            byte_next = s_data.in_char;
            end_next  = s_data.end_of_run;
        end

        if (go) begin
            if (cmd.hold_amp) begin
                buf_next[0] = byte_reg;
                count_next  = CNT_W'(1);
            end
            if (cmd.append) begin
                buf_next[count_reg[IDX_W-1:0]] = byte_reg;
                count_next = count_reg + CNT_W'(1);
            end
            if (cmd.latch_ent) begin
                ent_char_next = hit_val;
                count_next    = '0;
            end
            if (cmd.put_en) begin
                if (!full) begin
                    if (put_white) begin
                        sp_next = 1'b1;
                    end else begin
                        sp_next      = 1'b0;
                        emitted_next = emitted_reg + LEN_W'(1);
                    end
                end
                if (put_done && cmd.put_src == SRC_HELD) idx_next = idx_reg + CNT_W'(1);
            end
            if (cmd.flush_clear) begin
                count_next = '0;
                idx_next   = '0;
            end
            if (cmd.emit_end) begin
                count_next   = '0;
                sp_next      = 1'b0;
                emitted_next = '0;
            end
        end

        // Staging: a result waits in the hold slot until the next one shows
        // whether it was the last of its item
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_new) begin
            if (hold_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = hold_data_reg;
            end
            hold_valid_next = 1'b1;
            hold_data_next  = new_item;
        end else if (go && cmd.finish && hold_valid_reg) begin
            m_valid_next     = 1'b1;
            m_data_next      = hold_data_reg;
            m_data_next.last = 1'b1;
            hold_valid_next  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            idx_reg        <= '0;
            sp_reg         <= 1'b0;
            emitted_reg    <= '0;
            max_reg        <= MAX_OUTPUT_CHARS_RST;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            sp_reg         <= sp_next;
            emitted_reg    <= emitted_next;
            max_reg        <= max_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        end_reg       <= end_next;
        buf_reg       <= buf_next;
        ent_char_reg  <= ent_char_next;
        hold_data_reg <= hold_data_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // Staged result must survive while the output side stalls
    a_hold_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && m_valid_reg && !m_ready) |=>
            (hold_valid_reg && $stable(hold_data_reg)))
        else $error("staged result lost during output stall");

    // Replay index never passes the held count, which stays within the buffer
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_W'(LOOKAHEAD_DEPTH)) && (idx_reg <= count_reg))
        else $error("held count or replay index out of range");

    // End result leaves a clean run state behind
    a_run_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && cmd.emit_end) |=> (emitted_reg == '0 && !sp_reg && count_reg == '0))
        else $error("run state not cleared after end result");
`endif

endmodule

// File: src/text_entity_decode_space_collapse.sv
// Path: a plain byte's character goes through byte_reg, the hold slot and the
// output register to m_. A byte steps through take, replay of held bytes if any,
// put, end report at run end and finish; bytes are taken one at a time (s_ready
// only in idle or finish), and a stalled m_ side stretches every output step.
// Reset: synchronous active-low aresetn clears run state and the output
// channel and loads max_output_chars with 767; no clearing pass is needed.
// ============================================================================
// text_entity_decode_space_collapse
// Streaming text-run decoder: &lt; &gt; &amp; &nbsp; entity decoding and
// whitespace collapsing with output capacity limit and run length report.
// ============================================================================
module text_entity_decode_space_collapse #(
    parameter int LOOKAHEAD_DEPTH = tedsc_pkg::LOOKAHEAD_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tedsc_pkg::in_item_t         s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tedsc_pkg::out_item_t        m_data,
    input  logic                        cfg_wr_en,
    input  logic [tedsc_pkg::LEN_W-1:0] cfg_wr_data
);
    import tedsc_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // Sequencer
    tedsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath
    tedsc_dp #(
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

// File: sim/tb_text_entity_decode_space_collapse.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_text_entity_decode_space_collapse
// Self-checking bench for the text-run decoder. Bytes go in over the s_
// channel and a behavioral decoder in the bench predicts every character and
// end result. The predictor decodes entities, collapses whitespace and applies
// the capacity limit. A checker compares each m_ transfer field by field.
// Directed runs cover the entities, broken prefixes and the capacity edges.
// A long run overruns a small capacity. Random runs of well-formed tokens,
// mixed with noise, finish the test. Both sides stall at random.
// ============================================================================
module tb_text_entity_decode_space_collapse;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;      // settle time once the predicted results are in
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TIMEOUT_NS    = 8_000_000;
    localparam int RANDOM_BYTES  = 30;
    localparam int QUIET_TAIL    = 22;     // sent bytes after which idling stops
    localparam int LONG_RUN_LEN  = 24;
    localparam int CAP_LONG_RUN  = 16;
    localparam int MAX_PRINTED   = 50;

    localparam int RESULTS_PER_BYTE = 8;   // most results one transfer can cause
    localparam int HELD_DEPTH       = 5;
    localparam int ENTITY_KINDS     = 4;
    localparam int CAP_AT_RESET     = 767;
    localparam int CAP_FULL_SCALE   = 1023;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_UC_A     = 8'h41;
    localparam logic [7:0] CH_UC_Z     = 8'h5A;
    localparam logic [7:0] CH_LC_A     = 8'h61;
    localparam logic [7:0] CH_LC_Z     = 8'h7A;
    localparam logic [7:0] CH_FILL     = 8'h78;
    localparam logic [7:0] CH_TOP      = 8'hFF;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum int {
        ENTITY_LT,
        ENTITY_GT,
        ENTITY_AMP,
        ENTITY_NBSP
    } entity_kind_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tedsc_pkg::in_item_t   s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    tedsc_pkg::out_item_t  m_data;
    logic                  cfg_wr_en;
    logic [9:0]            cfg_wr_data;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    bit                    idle_on = 1'b1;
    int                    stall_left = 0;
    int                    error_count = 0;
    int                    sent_bytes = 0;
    logic [7:0]            run_bytes [$];

    // Decoder state mirrored by the predictor
    logic [7:0]            held_bytes [HELD_DEPTH];
    int                    held_n;
    bit                    space_owed;
    int                    emitted_n;
    int                    capacity;
    int                    byte_results_n;
    tedsc_pkg::out_item_t  byte_out_q [$];
    tedsc_pkg::out_item_t  decoded_q [$];

    text_entity_decode_space_collapse u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Character helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic string entity_text(input entity_kind_t k);
        case (k)
            ENTITY_LT:   return "&lt;";
            ENTITY_GT:   return "&gt;";
            ENTITY_AMP:  return "&amp;";
            ENTITY_NBSP: return "&nbsp;";
            default:     return "";
        endcase
    endfunction

    function automatic logic [7:0] entity_value(input entity_kind_t k);
        case (k)
            ENTITY_LT:   return CH_LT;
            ENTITY_GT:   return CH_GT;
            ENTITY_AMP:  return CH_AMP;
            default:     return CH_SPACE;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic reset_decoder_model();
        held_n     = 0;
        space_owed = 1'b0;
        emitted_n  = 0;
        capacity   = CAP_AT_RESET;
    endtask

    // Results past the per-byte limit are dropped
    task automatic push_result(input logic [7:0] ch, input bit done, input int len);
        tedsc_pkg::out_item_t r;
        if (byte_results_n < RESULTS_PER_BYTE) begin
            r.out_char   = ch;
            r.is_end     = done;
            r.run_length = 10'(len);
            r.last       = 1'b0;
            byte_out_q.push_back(r);
            byte_results_n++;
        end
    endtask

    // Emit one character with whitespace collapsing and the capacity limit
    task automatic place_char(input logic [7:0] c);
        if (emitted_n >= capacity)
            return;
        if (is_blank(c)) begin
            space_owed = 1'b1;
            return;
        end
        // the pending space only goes out if the character fits after it
        if (space_owed && emitted_n > 0 && emitted_n + 1 < capacity) begin
            push_result(CH_SPACE, 1'b0, 0);
            emitted_n++;
        end
        space_owed = 1'b0;
        push_result(c, 1'b0, 0);
        emitted_n++;
    endtask

    task automatic replay_held();
        int i;
        for (i = 0; i < held_n; i++)
            place_char(held_bytes[i]);
        held_n = 0;
    endtask

    task automatic start_fresh(input logic [7:0] b);
        if (b == CH_AMP) begin
            held_bytes[0] = b;
            held_n        = 1;
        end else begin
            place_char(b);
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int    i;
        int    k;
        int    n;
        bit    ok;
        string t;
        if (emitted_n >= capacity)
            return;
        if (held_n == 0) begin
            start_fresh(b);
            return;
        end
        // first entity whose spelling continues the held prefix wins
        for (k = 0; k < ENTITY_KINDS; k++) begin
            t  = entity_text(entity_kind_t'(k));
            n  = held_n + 1;
            ok = n <= t.len();
            for (i = 0; ok && i < held_n; i++)
                if (lower_case(held_bytes[i]) != lower_case(t[i]))
                    ok = 1'b0;
            if (ok && lower_case(b) != lower_case(t[held_n]))
                ok = 1'b0;
            if (ok) begin
                if (n == t.len()) begin
                    held_n = 0;
                    place_char(entity_value(entity_kind_t'(k)));
                end else if (held_n < HELD_DEPTH) begin
                    held_bytes[held_n] = b;
                    held_n++;
                end else begin
                    replay_held();
                    start_fresh(b);
                end
                return;
            end
        end
        // no entity continues: replay held bytes literally, retry the byte
        replay_held();
        if (emitted_n >= capacity)
            return;
        start_fresh(b);
    endtask

    task automatic decode_byte(input tedsc_pkg::in_item_t it);
        tedsc_pkg::out_item_t r;
        int i;
        byte_out_q.delete();
        byte_results_n = 0;
        absorb_byte(it.in_char);
        if (it.end_of_run) begin
            replay_held();
            push_result(CH_NUL, 1'b1, emitted_n);
            held_n     = 0;
            space_owed = 1'b0;
            emitted_n  = 0;
        end
        if (byte_out_q.size() > 0) begin
            r      = byte_out_q[byte_out_q.size() - 1];
            r.last = 1'b1;
            byte_out_q[byte_out_q.size() - 1] = r;
        end
        for (i = 0; i < byte_out_q.size(); i++)
            decoded_q.push_back(byte_out_q[i]);
    endtask

    // ------------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    always @(posedge aclk) begin : check_results
        tedsc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result char %02h end %0d len %0d",
                    m_data.out_char, m_data.is_end, m_data.run_length));
            end else begin
                want = decoded_q.pop_front();
                if (m_data.out_char !== want.out_char)
                    report_mismatch($sformatf("out_char %02h, want %02h",
                        m_data.out_char, want.out_char));
                if (m_data.is_end !== want.is_end)
                    report_mismatch($sformatf("is_end %0d, want %0d",
                        m_data.is_end, want.is_end));
                if (m_data.run_length !== want.run_length)
                    report_mismatch($sformatf("run_length %0d, want %0d",
                        m_data.run_length, want.run_length));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d",
                        m_data.last, want.last));
            end
        end
    end

    // Result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (!idle_on) begin
            stall_left = 0;
            m_ready   <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready   <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready   <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus primitives
    // ------------------------------------------------------------------------
    // One byte transfer; valid stays high into the next call unless a gap is drawn
    task automatic send_byte(input logic [7:0] ch, input bit last_byte);
        tedsc_pkg::in_item_t it;
        int gap;
        it.in_char    = ch;
        it.end_of_run = last_byte;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap      = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent_bytes++;
        decode_byte(it);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_run();
        int i;
        for (i = 0; i < run_bytes.size(); i++)
            send_byte(run_bytes[i], i == run_bytes.size() - 1);
    endtask

    // Hold the sender until every predicted result has come, then let the block settle
    task automatic drain_results();
        tedsc_pkg::out_item_t lost;
        int waited;
        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (decoded_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (decoded_q.size() != 0) begin
            lost = decoded_q.pop_front();
            report_mismatch($sformatf("missing result char %02h end %0d len %0d",
                lost.out_char, lost.is_end, lost.run_length));
        end
    endtask

    task automatic write_capacity(input logic [9:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        capacity     = value;
    endtask

    // Append one token of a text run: entity, blanks, word, broken entity or noise
    task automatic add_token();
        string       t;
        logic [7:0]  c;
        int          i;
        int          n;
        int          pick;
        pick = $urandom_range(0, 9);
        t    = entity_text(entity_kind_t'($urandom_range(0, ENTITY_KINDS - 1)));
        if (pick <= 3) begin
            // entity in random letter case
            for (i = 0; i < t.len(); i++) begin
                c = t[i];
                if (c >= CH_LC_A && c <= CH_LC_Z && $urandom_range(0, 1))
                    c = c - CASE_OFFSET;
                run_bytes.push_back(c);
            end
        end else if (pick == 4) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                case ($urandom_range(0, 3))
                    0:       run_bytes.push_back(CH_SPACE);
                    1:       run_bytes.push_back(CH_TAB);
                    2:       run_bytes.push_back(CH_CR);
                    default: run_bytes.push_back(CH_LF);
                endcase
        end else if (pick <= 6) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                run_bytes.push_back(8'($urandom_range(33, 126)));
        end else if (pick <= 8) begin
            // proper prefix of an entity, then any byte
            n = $urandom_range(1, t.len() - 1);
            for (i = 0; i < n; i++)
                run_bytes.push_back(t[i]);
            run_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            run_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset capacity; all four entities in mixed case, leading and trailing blanks
    task automatic test_entity_decoding();
        idle_on = 1'b1;
        send_text("\t&Lt;&gT;&AmP;&NBSP;y ");
        drain_results();
    endtask

    // Failed prefixes replay literally; a full held prefix is replayed at the end of
    // a run, and the last run ends with a byte still held
    task automatic test_broken_entities();
        idle_on = 1'b1;
        send_byte(CH_AMP, 1'b0);
        send_byte("a", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_TOP, 1'b0);
        send_text(" &nbsp");
        send_byte(CH_AMP, 1'b1);
        drain_results();
    endtask

    // Zero capacity, space dropped at the edge, entity filling the last slot
    task automatic test_capacity_edges();
        idle_on = 1'b1;
        write_capacity(10'd0);
        send_text("ab");
        write_capacity(10'd2);
        send_text("a bc");
        write_capacity(10'd3);
        send_text("x &lt;&amp;y");
        write_capacity(10'd1);
        send_text("  zq");
        drain_results();
    endtask

    // Capacity reached by one long run of plain characters; later bytes are ignored
    task automatic test_full_capacity();
        logic [7:0] c;
        int i;
        idle_on = 1'b0;
        write_capacity(10'(CAP_LONG_RUN));
        run_bytes.delete();
        for (i = 0; i < LONG_RUN_LEN; i++) begin
            c = 8'($urandom_range(0, 255));
            if (is_blank(c) || c == CH_AMP)
                c = CH_FILL;
            run_bytes.push_back(c);
        end
        send_run();
        drain_results();
    endtask

    // Random runs of tokens under changing capacity; quiet handshakes at the end
    task automatic test_random_runs();
        int runs;
        int n;
        int i;
        runs       = 0;
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (runs % 5 == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_capacity(10'd1);
                    1:       write_capacity(10'($urandom_range(2, 12)));
                    2:       write_capacity(10'($urandom_range(13, CAP_FULL_SCALE)));
                    default: write_capacity(10'(CAP_AT_RESET));
                endcase
            end
            idle_on = (sent_bytes < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            run_bytes.delete();
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
                add_token();
            send_run();
            runs++;
        end
        idle_on = 1'b0;
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        reset_decoder_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_entity_decoding();
        test_broken_entities();
        test_capacity_edges();
        test_full_capacity();
        test_random_runs();

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
